FILE: design/cnht_pkg.sv
package cnht_pkg;

  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned HASH_W      = 32;
  localparam int unsigned NAME_W      = 64;
  localparam int unsigned SPC_W       = 3;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned ST_W        = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;

  // result index source
  localparam logic [1:0] SEL_ZERO = 2'd0;
  localparam logic [1:0] SEL_CUR  = 2'd1;
  localparam logic [1:0] SEL_FILL = 2'd2;

  typedef struct packed {
    logic            load;
    logic            hash_step;
    logic            div_step;
    logic            head_rd;
    logic            cur_from_head;
    logic            ent_rd;
    logic            ins_fix;
    logic            advance;
    logic            ins_wr;
    logic            pend_ld;
    logic [ST_W-1:0] pend_status;
    logic [1:0]      pend_sel;
    logic            out_ld;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            hash_last;
    logic            div_last;
    logic            cur_vld;
    logic            head_ok;
    logic            hit;
  } stat_t;

  // one stored entry: upper-cased name, namespace, home bucket, chain link (MSB = nil)
  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [SPC_W-1:0]  space;
    logic [IDX_W-1:0]  bucket;
    logic [IDX_W:0]    link;
  } entry_t;

  function automatic logic [7:0] upcase(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h61 && b <= 8'h7A) r = b - 8'h20;
    return r;
  endfunction

  // zero bytes after the first NUL, upper-case the rest
  function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] w);
    logic [NAME_W-1:0] r;
    logic              dead;
    r    = '0;
    dead = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (w[i*8 +: 8] == 8'h00) dead = 1'b1;
      if (!dead) r[i*8 +: 8] = upcase(w[i*8 +: 8]);
    end
    return r;
  endfunction

endpackage

FILE: design/cnht_if.sv
interface cnht_in_if;
  logic                            valid;
  logic                            ready;
  logic [cnht_pkg::OP_W-1:0]       operation;
  logic [cnht_pkg::NAME_W-1:0]     name_bytes;
  logic [cnht_pkg::SPC_W-1:0]      name_space;
  modport source (output valid, operation, name_bytes, name_space, input ready);
  modport sink   (input valid, operation, name_bytes, name_space, output ready);
endinterface

interface cnht_out_if;
  logic                        valid;
  logic                        ready;
  logic [cnht_pkg::ST_W-1:0]   status;
  logic [cnht_pkg::IDX_W-1:0]  entry_index;
  modport source (output valid, status, entry_index, input ready);
  modport sink   (input valid, status, entry_index, output ready);
endinterface

FILE: design/cnht_datapath.sv
module cnht_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cnht_pkg::cmd_t                cmd_i,
  output cnht_pkg::stat_t               stat_o,
  input  logic [cnht_pkg::OP_W-1:0]     operation_i,
  input  logic [cnht_pkg::NAME_W-1:0]   name_bytes_i,
  input  logic [cnht_pkg::SPC_W-1:0]    name_space_i,
  input  logic                          cfg_we_i,
  input  logic [cnht_pkg::CNT_W-1:0]    cfg_wdata_i,
  output logic [cnht_pkg::ST_W-1:0]     status_o,
  output logic [cnht_pkg::IDX_W-1:0]    entry_index_o
);

  localparam int unsigned IW = cnht_pkg::IDX_W;
  localparam int unsigned CW = cnht_pkg::CNT_W;
  localparam int unsigned HW = cnht_pkg::HASH_W;

  // control state
  logic [CW-1:0]  cnt_q, fill_q;
  // working registers
  logic [cnht_pkg::OP_W-1:0]   op_q;
  logic [cnht_pkg::NAME_W-1:0] name_q;
  logic [cnht_pkg::SPC_W-1:0]  space_q;
  logic [HW-1:0]               h_q;
  logic [2:0]                  bi_q;
  logic [4:0]                  d_q;
  logic [IW-1:0]               rem_q, cur_q;
  logic                        cur_vld_q, first_q;
  logic [cnht_pkg::ST_W-1:0]   pend_st_q, out_st_q;
  logic [IW-1:0]               pend_idx_q, out_idx_q;

  // memories
  logic [IW-1:0]          head_mem [cnht_pkg::MAX_ENTRIES];
  cnht_pkg::entry_t       ent_mem  [cnht_pkg::MAX_ENTRIES];
  logic [IW-1:0]          head_rdata_q;
  cnht_pkg::entry_t       ent_rdata_q;

  logic [CW-1:0]  cnt_used;
  logic [7:0]     cur_byte;
  logic [CW-1:0]  div_t, div_r;
  logic           head_ok;
  cnht_pkg::entry_t new_ent;

  // clamp entry count to 1..MAX_ENTRIES
  always_comb begin
    cnt_used = cnt_q;
    if (cnt_q == '0) cnt_used = CW'(1);
    if (cnt_q > CW'(cnht_pkg::MAX_ENTRIES)) cnt_used = CW'(cnht_pkg::MAX_ENTRIES);
  end

  assign cur_byte = name_q[{bi_q, 3'b000} +: 8];
  assign div_t    = {rem_q, h_q[HW-1]};
  assign div_r    = (div_t >= cnt_used) ? div_t - cnt_used : div_t;
  assign head_ok  = !first_q || (ent_rdata_q.bucket == rem_q);

  always_comb begin
    new_ent.name   = name_q;
    new_ent.space  = space_q;
    new_ent.bucket = rem_q;
    new_ent.link   = cur_vld_q ? {1'b0, cur_q} : {1'b1, {IW{1'b0}}};
  end

  // status to controller
  always_comb begin
    stat_o.op        = op_q;
    stat_o.full      = fill_q >= cnt_used;
    stat_o.hash_last = (bi_q == 3'd7) || (cur_byte == 8'h00);
    stat_o.div_last  = d_q == 5'd31;
    stat_o.cur_vld   = cur_vld_q;
    stat_o.head_ok   = head_ok;
    stat_o.hit       = head_ok && (ent_rdata_q.name == name_q) && (ent_rdata_q.space == space_q);
  end

  // config and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= CW'(1024);
      fill_q <= '0;
    end else begin
      if (cfg_we_i) cnt_q <= cfg_wdata_i;
      if (cmd_i.load && operation_i == cnht_pkg::OP_CLEAR) fill_q <= '0;
      else if (cmd_i.ins_wr) fill_q <= fill_q + CW'(1);
    end
  end

  // hash, divide and chain-walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      name_q  <= cnht_pkg::clean_name(name_bytes_i);
      space_q <= name_space_i;
      h_q     <= HW'(cnht_pkg::upcase(name_bytes_i[7:0]));
      bi_q    <= 3'd1;
      d_q     <= '0;
      rem_q   <= '0;
    end
    if (cmd_i.hash_step) begin
      bi_q <= bi_q + 3'd1;
      if (!(cur_byte == 8'h00 && bi_q != 3'd7)) begin
        if (bi_q == 3'd1) h_q <= h_q + (h_q << 1) + HW'(cur_byte);
        else              h_q <= (h_q << 1) + HW'(cur_byte);
      end
    end
    if (cmd_i.div_step) begin
      rem_q <= div_r[IW-1:0];
      h_q   <= h_q << 1;
      d_q   <= d_q + 5'd1;
    end
    if (cmd_i.cur_from_head) begin
      cur_q     <= head_rdata_q;
      cur_vld_q <= {1'b0, head_rdata_q} < fill_q;
      first_q   <= 1'b1;
    end
    if (cmd_i.ins_fix) cur_vld_q <= cur_vld_q & head_ok;
    if (cmd_i.advance) begin
      cur_q     <= ent_rdata_q.link[IW-1:0];
      cur_vld_q <= !ent_rdata_q.link[IW];
      first_q   <= 1'b0;
    end
    if (cmd_i.pend_ld) begin
      pend_st_q <= cmd_i.pend_status;
      case (cmd_i.pend_sel)
        cnht_pkg::SEL_CUR:  pend_idx_q <= cur_q;
        cnht_pkg::SEL_FILL: pend_idx_q <= fill_q[IW-1:0];
        default:            pend_idx_q <= '0;
      endcase
    end
    if (cmd_i.out_ld) begin
      out_st_q  <= pend_st_q;
      out_idx_q <= pend_idx_q;
    end
  end

  // chain head memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.head_rd) head_rdata_q <= head_mem[rem_q];
    if (cmd_i.ins_wr)  head_mem[rem_q] <= fill_q[IW-1:0];
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.ent_rd) ent_rdata_q <= ent_mem[cur_q];
    if (cmd_i.ins_wr) ent_mem[fill_q[IW-1:0]] <= new_ent;
  end

  assign status_o      = out_st_q;
  assign entry_index_o = out_idx_q;

endmodule

FILE: design/cnht_ctrl.sv
module cnht_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  cnht_pkg::stat_t  stat_i,
  output cnht_pkg::cmd_t   cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_HASH = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_HRD  = 4'd4;
  localparam logic [3:0] S_HLD  = 4'd5;
  localparam logic [3:0] S_ERD  = 4'd6;
  localparam logic [3:0] S_ECHK = 4'd7;
  localparam logic [3:0] S_INS  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.op == cnht_pkg::OP_INSERT && stat_i.full) begin
          cmd_o.pend_ld     = 1'b1;
          cmd_o.pend_status = cnht_pkg::ST_FULL;
          cmd_o.pend_sel    = cnht_pkg::SEL_ZERO;
          state_d           = S_DONE;
        end else if (stat_i.op == cnht_pkg::OP_INSERT || stat_i.op == cnht_pkg::OP_LOOKUP) begin
          state_d = S_HASH;
        end else begin
          cmd_o.pend_ld     = 1'b1;
          cmd_o.pend_status = cnht_pkg::ST_OK;
          cmd_o.pend_sel    = cnht_pkg::SEL_ZERO;
          state_d           = S_DONE;
        end
      end
      S_HASH: begin
        cmd_o.hash_step = 1'b1;
        if (stat_i.hash_last) state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_HRD;
      end
      S_HRD: begin
        cmd_o.head_rd = 1'b1;
        state_d       = S_HLD;
      end
      S_HLD: begin
        cmd_o.cur_from_head = 1'b1;
        state_d             = S_ERD;
      end
      S_ERD: begin
        if (stat_i.cur_vld) begin
          cmd_o.ent_rd = 1'b1;
          state_d      = S_ECHK;
        end else if (stat_i.op == cnht_pkg::OP_INSERT) begin
          state_d = S_INS;
        end else begin
          cmd_o.pend_ld     = 1'b1;
          cmd_o.pend_status = cnht_pkg::ST_NOTFOUND;
          cmd_o.pend_sel    = cnht_pkg::SEL_ZERO;
          state_d           = S_DONE;
        end
      end
      S_ECHK: begin
        if (stat_i.op == cnht_pkg::OP_INSERT) begin
          // stale head from before a clear counts as an empty chain
          cmd_o.ins_fix = 1'b1;
          state_d       = S_INS;
        end else if (stat_i.hit) begin
          cmd_o.pend_ld     = 1'b1;
          cmd_o.pend_status = cnht_pkg::ST_OK;
          cmd_o.pend_sel    = cnht_pkg::SEL_CUR;
          state_d           = S_DONE;
        end else if (!stat_i.head_ok) begin
          cmd_o.pend_ld     = 1'b1;
          cmd_o.pend_status = cnht_pkg::ST_NOTFOUND;
          cmd_o.pend_sel    = cnht_pkg::SEL_ZERO;
          state_d           = S_DONE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_ERD;
        end
      end
      S_INS: begin
        cmd_o.ins_wr      = 1'b1;
        cmd_o.pend_ld     = 1'b1;
        cmd_o.pend_status = cnht_pkg::ST_OK;
        cmd_o.pend_sel    = cnht_pkg::SEL_FILL;
        state_d           = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output word valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_ld) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: design/chained_name_hash_table.sv
// Clear and unused codes, and an insert into a full table, go from dispatch to done.
// Lookup hashes in 1..7 steps, takes 32 bit-serial remainder steps, reads the bucket
// head, then probes the chain one entry at a time; insert runs the same front part,
// checks the head entry when the bucket holds a chain and writes the new entry.
// One word in flight; a new word is taken while the result waits in the output reg.
// Reset: chains empty, fill count 0, entry_count 1024; no clearing pass needed.
module chained_name_hash_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  cnht_in_if.sink                    in_i,
  cnht_out_if.source                 out_o,
  input  logic                       cfg_we_i,
  input  logic [cnht_pkg::CNT_W-1:0] cfg_wdata_i
);

  cnht_pkg::cmd_t  cmd;
  cnht_pkg::stat_t stat;

  cnht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cnht_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .operation_i   (in_i.operation),
    .name_bytes_i  (in_i.name_bytes),
    .name_space_i  (in_i.name_space),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .status_o      (out_o.status),
    .entry_index_o (out_o.entry_index)
  );

endmodule
